>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, checked every clock outside reset
`define SWZ_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("swz assertion failed");

// same-cycle implication
`define SWZ_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    `SWZ_ASSERT(lbl, clk, rst_n, (ante) |-> (cons))

// next-cycle implication
`define SWZ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    `SWZ_ASSERT(lbl, clk, rst_n, (ante) |=> (cons))

`endif

>>> rtl/swz_pkg.sv
package swz_pkg;

    localparam int MAX_WINDOW_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int LEN_BITS        = 9;
    localparam int LEN_MIN         = 2;
    localparam int LEN_RESET       = 256;
    localparam int SIGMA_BITS      = 16;
    localparam int FRAC_BITS       = 16;
    localparam int QUO_BITS        = 32;
    localparam int ROOT_BITS       = 16;
    localparam int CFG_IDX_BITS    = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_LEN  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_LOW  = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HIGH = 2'd2;

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_FEW   = 2'd1,
        ST_FLAT  = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_UPD,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_MUL4,
        S_DIVI,
        S_DIV,
        S_SQRT,
        S_DONE
    } t_state;

endpackage

>>> rtl/swz_in_if.sv
interface swz_in_if #(
    parameter int SAMPLE_BITS = swz_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/swz_out_if.sv
interface swz_out_if;
    logic                            valid;
    logic                            ready;
    logic [swz_pkg::SIGMA_BITS-1:0]  sigma;
    swz_pkg::t_status                status;

    modport source (output valid, output sigma, output status, input ready);
    modport sink (input valid, input sigma, input status, output ready);
endinterface

>>> rtl/sliding_window_zscore_unit.sv
// channel   dir  handshake        payload
// i_in      in   valid / ready    sample (SAMPLE_BITS, unsigned)
// o_out     out  valid / ready    sigma (16, Q8.8), status (2)
// i_cfg     in   i_cfg_we         i_cfg_idx, i_cfg_data
//
// an item goes from accept to result through window read and update, four multiply
// steps, divider setup, a 32-step restoring divider and a 16-step square root; it ends
// after the third multiply step with fewer than two samples or zero spread, and after
// divider setup when the quotient saturates. ready is high only while the sequencer is
// idle. reset restores config defaults, clears window state, not the sample memory.
// one finished result waits in the output register; a new item is taken meanwhile.
`include "assert_macros.svh"

module sliding_window_zscore_unit #(
    parameter int MAX_WINDOW  = swz_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = swz_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [swz_pkg::CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [((SAMPLE_BITS > swz_pkg::LEN_BITS) ? SAMPLE_BITS
                   : swz_pkg::LEN_BITS)-1:0]  i_cfg_data,
    swz_in_if.sink                            i_in,
    swz_out_if.source                         o_out
);
    localparam int SB    = SAMPLE_BITS;
    localparam int AW    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int NW    = $clog2(MAX_WINDOW + 1);
    localparam int SUMW  = SB + AW;
    localparam int SQW   = 2 * SB + AW;
    localparam int NSQW  = SQW + AW;
    localparam int AWID  = NSQW + AW;
    localparam int BW    = 2 * SUMW + AW + swz_pkg::FRAC_BITS;
    localparam int QB    = swz_pkg::QUO_BITS;
    localparam int RB    = swz_pkg::ROOT_BITS;
    localparam int CNTW  = $clog2(QB);
    localparam int RBW   = $clog2(RB);
    localparam int LEN_RST = (swz_pkg::LEN_RESET > MAX_WINDOW) ? MAX_WINDOW
                             : swz_pkg::LEN_RESET;

    swz_pkg::t_state r_state, n_state;

    logic [NW-1:0]    r_len_eff;
    logic [SB-1:0]    r_low, r_high;
    logic [AW-1:0]    r_ptr;
    logic [NW-1:0]    r_fill;
    logic [SUMW-1:0]  r_sum;
    logic [SQW-1:0]   r_sumsq;
    logic [SB-1:0]    r_x;
    logic [AW-1:0]    r_idx;
    logic             r_full;
    logic [NW-1:0]    r_n;
    logic [SUMW-1:0]  r_nx;
    logic [NSQW-1:0]  r_sum2, r_nsq, r_spread;
    logic [SUMW-1:0]  r_dev;
    logic [AWID-1:0]  r_a, r_rem;
    logic [2*SUMW-1:0] r_dd;
    logic [BW-1:0]    r_b;
    logic [QB-1:0]    r_quo;
    logic [RB-1:0]    r_root;
    logic [CNTW-1:0]  r_cnt;
    logic [swz_pkg::SIGMA_BITS-1:0] r_res_sigma, r_out_sigma;
    swz_pkg::t_status r_res_status, r_out_status;
    logic             r_out_valid;

    logic             w_in_acc, w_full, w_out_load, w_few, w_flat, w_ovf, w_ge, w_root_ok;
    logic             w_out_few;
    logic [SB-1:0]    w_range, w_xoff, w_x;
    logic [NW:0]      w_pos;
    logic [AW-1:0]    w_idx;
    logic [NW-1:0]    w_idx_inc, w_nm1;
    logic [SB-1:0]    w_old;
    logic [2*SB-1:0]  w_old_sq, w_x_sq;
    logic [NW+SB-1:0] w_p_nx;
    logic [2*SUMW-1:0] w_p_s2, w_p_dd;
    logic [NW+SQW-1:0] w_p_nsq;
    logic [NSQW+NW-1:0] w_p_a;
    logic [2*SUMW+NW-1:0] w_p_b;
    logic [AWID-1:0]  w_b_hi;
    logic [AWID:0]    w_trial;
    logic [RBW-1:0]   w_k;
    logic [RB-1:0]    w_try;
    logic [2*RB-1:0]  w_try_sq;

    // input clamp and offset
    always_comb begin
        w_range = (r_high > r_low) ? r_high - r_low : '0;
        w_xoff  = (i_in.sample > r_low) ? i_in.sample - r_low : '0;
        w_x     = (w_xoff > w_range) ? w_range : w_xoff;
    end

    // slot for the new sample
    always_comb begin
        w_full = (r_fill >= r_len_eff);
        w_pos  = (NW + 1)'(r_ptr) + (NW + 1)'(r_fill);
        if (w_pos >= (NW + 1)'(r_len_eff)) begin
            w_pos = w_pos - (NW + 1)'(r_len_eff);
        end
        if (w_pos >= (NW + 1)'(MAX_WINDOW)) begin
            w_pos = '0;
        end
        if (w_full) begin
            w_idx = (NW'(r_ptr) < r_len_eff) ? r_ptr : '0;
        end else begin
            w_idx = w_pos[AW-1:0];
        end
    end

    swz_ram #(
        .WIDTH (SB),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (r_state == swz_pkg::S_UPD),
        .i_waddr (r_idx),
        .i_wdata (r_x),
        .i_raddr (w_idx),
        .o_rdata (w_old)
    );

    always_comb begin
        w_in_acc   = i_in.valid && i_in.ready;
        w_out_load = (r_state == swz_pkg::S_DONE) && (!r_out_valid || o_out.ready);
        w_out_few  = o_out.valid && (o_out.status == swz_pkg::ST_FEW);
        w_old_sq   = (r_full ? w_old : '0) * (r_full ? w_old : '0);
        w_x_sq     = r_x * r_x;
        w_idx_inc  = NW'(r_idx) + NW'(1);
        w_p_nx     = r_n * r_x;
        w_p_s2     = r_sum * r_sum;
        w_p_nsq    = r_n * r_sumsq;
        w_few      = (r_n < NW'(swz_pkg::LEN_MIN));
        w_flat     = (r_spread == '0);
        w_p_a      = r_spread * r_n;
        w_p_dd     = r_dev * r_dev;
        w_nm1      = r_n - NW'(1);
        w_p_b      = r_dd * w_nm1;
        w_b_hi     = AWID'(r_b[BW-1:QB]);
        w_ovf      = (w_b_hi >= r_a);
        w_trial    = {r_rem, r_quo[QB-1]};
        w_ge       = (w_trial >= {1'b0, r_a});
        w_k        = RBW'(RB - 1) - r_cnt[RBW-1:0];
        w_try      = r_root | (RB'(1) << w_k);
        w_try_sq   = w_try * w_try;
        w_root_ok  = (w_try_sq <= r_quo);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            swz_pkg::S_IDLE: if (w_in_acc) n_state = swz_pkg::S_UPD;
            swz_pkg::S_UPD:  n_state = swz_pkg::S_MUL1;
            swz_pkg::S_MUL1: n_state = swz_pkg::S_MUL2;
            swz_pkg::S_MUL2: n_state = swz_pkg::S_MUL3;
            swz_pkg::S_MUL3: begin
                n_state = (w_few || w_flat) ? swz_pkg::S_DONE : swz_pkg::S_MUL4;
            end
            swz_pkg::S_MUL4: n_state = swz_pkg::S_DIVI;
            swz_pkg::S_DIVI: n_state = w_ovf ? swz_pkg::S_DONE : swz_pkg::S_DIV;
            swz_pkg::S_DIV: begin
                if (r_cnt == CNTW'(QB - 1)) n_state = swz_pkg::S_SQRT;
            end
            swz_pkg::S_SQRT: begin
                if (r_cnt[RBW-1:0] == RBW'(RB - 1)) n_state = swz_pkg::S_DONE;
            end
            swz_pkg::S_DONE: if (w_out_load) n_state = swz_pkg::S_IDLE;
            default: n_state = swz_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= swz_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // window state and configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len_eff <= NW'(LEN_RST);
            r_low     <= '0;
            r_high    <= '1;
            r_ptr     <= '0;
            r_fill    <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                swz_pkg::CFG_LEN: begin
                    if (32'(i_cfg_data) < swz_pkg::LEN_MIN) begin
                        r_len_eff <= NW'(swz_pkg::LEN_MIN);
                    end else if (32'(i_cfg_data) > MAX_WINDOW) begin
                        r_len_eff <= NW'(MAX_WINDOW);
                    end else begin
                        r_len_eff <= NW'(i_cfg_data);
                    end
                    r_ptr   <= '0;
                    r_fill  <= '0;
                    r_sum   <= '0;
                    r_sumsq <= '0;
                end
                swz_pkg::CFG_LOW:  r_low  <= i_cfg_data[SB-1:0];
                swz_pkg::CFG_HIGH: r_high <= i_cfg_data[SB-1:0];
                default: ;
            endcase
        end else if (r_state == swz_pkg::S_UPD) begin
            r_sum   <= r_sum - SUMW'(r_full ? w_old : '0) + SUMW'(r_x);
            r_sumsq <= r_sumsq - SQW'(w_old_sq) + SQW'(w_x_sq);
            if (r_full) begin
                r_ptr  <= (w_idx_inc >= r_len_eff) ? '0 : w_idx_inc[AW-1:0];
                r_fill <= r_len_eff;
            end else begin
                r_fill <= r_fill + NW'(1);
            end
        end
    end

    // arithmetic sequence
    always_ff @(posedge i_clk) begin
        case (r_state)
            swz_pkg::S_IDLE: begin
                if (w_in_acc) begin
                    r_x    <= w_x;
                    r_idx  <= w_idx;
                    r_full <= w_full;
                end
            end
            swz_pkg::S_UPD: begin
                r_n <= r_full ? r_len_eff : r_fill + NW'(1);
            end
            swz_pkg::S_MUL1: begin
                r_nx   <= w_p_nx[SUMW-1:0];
                r_sum2 <= NSQW'(w_p_s2);
                r_nsq  <= w_p_nsq[NSQW-1:0];
            end
            swz_pkg::S_MUL2: begin
                r_dev    <= (r_nx >= r_sum) ? r_nx - r_sum : r_sum - r_nx;
                r_spread <= r_nsq - r_sum2;
            end
            swz_pkg::S_MUL3: begin
                r_a  <= w_p_a[AWID-1:0];
                r_dd <= w_p_dd;
                if (w_few) begin
                    r_res_sigma  <= '0;
                    r_res_status <= swz_pkg::ST_FEW;
                end else begin
                    r_res_sigma  <= (r_dev == '0) ? '0 : '1;
                    r_res_status <= swz_pkg::ST_FLAT;
                end
            end
            swz_pkg::S_MUL4: begin
                r_b <= {w_p_b[2*SUMW+AW-1:0], {swz_pkg::FRAC_BITS{1'b0}}};
            end
            swz_pkg::S_DIVI: begin
                r_rem        <= w_b_hi;
                r_quo        <= r_b[QB-1:0];
                r_cnt        <= '0;
                r_res_sigma  <= '1;
                r_res_status <= swz_pkg::ST_VALID;
            end
            swz_pkg::S_DIV: begin
                // restoring step; quotient bits shift in as dividend bits leave
                r_rem  <= w_ge ? AWID'(w_trial - {1'b0, r_a}) : w_trial[AWID-1:0];
                r_quo  <= {r_quo[QB-2:0], w_ge};
                r_cnt  <= (r_cnt == CNTW'(QB - 1)) ? '0 : r_cnt + CNTW'(1);
                r_root <= '0;
            end
            swz_pkg::S_SQRT: begin
                if (w_root_ok) r_root <= w_try;
                r_res_sigma <= w_root_ok ? w_try : r_root;
                r_cnt       <= r_cnt + CNTW'(1);
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_sigma  <= r_res_sigma;
            r_out_status <= r_res_status;
        end
    end

    assign i_in.ready   = (r_state == swz_pkg::S_IDLE);
    assign o_out.valid  = r_out_valid;
    assign o_out.sigma  = r_out_sigma;
    assign o_out.status = r_out_status;

    `SWZ_ASSERT(a_fill_in_len, i_clk, i_rst_n, r_fill <= r_len_eff)
    `SWZ_ASSERT(a_ptr_in_win, i_clk, i_rst_n, NW'(r_ptr) < r_len_eff)
    `SWZ_ASSERT_NEXT(a_acc_upd, i_clk, i_rst_n, w_in_acc, r_state == swz_pkg::S_UPD)
    `SWZ_ASSERT_IMP(a_few_zero, i_clk, i_rst_n, w_out_few, o_out.sigma == '0)
endmodule

>>> rtl/swz_ram.sv
module swz_ram #(
    parameter int WIDTH = swz_pkg::SAMPLE_BITS_DEF,
    parameter int DEPTH = swz_pkg::MAX_WINDOW_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
